// ===== rtl/direct_mapped_cache_defines.svh =====
// Assertion macros used by the checker module of the direct-mapped cache.
`ifndef DIRECT_MAPPED_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DMC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DMC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dmc_pkg.sv =====
// Types and constants shared by the direct-mapped cache and its checker.
package dmc_pkg;

    localparam int DMC_LINES          = 64;
    localparam int DMC_WORDS_PER_LINE = 4;
    localparam int DMC_ADDR_BITS      = 32;

    localparam int ADDR_W = 32;
    localparam int DATA_W = 32;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [ADDR_W-1:0]        address;
        logic signed [DATA_W-1:0] write_data;
    } dmc_req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_data;
    } dmc_rsp_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } dmc_state_t;

endpackage

// ===== rtl/direct_mapped_cache.sv =====
// Direct-mapped, write-allocate cache with one data word per word offset.
//
// Requests arrive on the s_ channel (mode, address, write data) and every
// transfer there yields exactly one response transfer on the m_ channel
// (hit flag and read data), in order.
// A read hit returns the stored word, a read miss returns all ones, and a
// write always allocates the line and returns zero, with hit telling
// whether the line already held the tag.
// The line store and the data store are synchronous memories with a
// registered read; a request reads both at its transfer, and the result is
// registered and any write committed when the request stage completes.
// m_valid is set when the request stage hands its result on, so the request
// and response registers lie between a request and its response. One request
// is taken every cycle while the response side keeps pace; a write followed at
// once by an access to the same line is forwarded, not stalled.
// After reset the block sweeps both memories, one data word and at most one
// line per cycle, over all LINES*WORDS_PER_LINE words (256 by default), and
// holds s_ready low until the sweep is over.
// When m_ready is low the response register holds its transfer; the request
// in flight then waits, and s_ready falls until the response is taken.
module direct_mapped_cache #(
    parameter int LINES          = dmc_pkg::DMC_LINES,
    parameter int WORDS_PER_LINE = dmc_pkg::DMC_WORDS_PER_LINE,
    parameter int ADDR_BITS      = dmc_pkg::DMC_ADDR_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dmc_pkg::dmc_req_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dmc_pkg::dmc_rsp_t  m_data
);
    import dmc_pkg::*;

    localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int IB       = $clog2(LINES + 1) - 1;
    localparam int OB       = $clog2(WORDS_PER_LINE + 1) - 1;
    localparam int IDX_W    = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int DEPTH    = LINES * WORDS_PER_LINE;
    localparam int SLOT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TAG_W    = (EFF_BITS > IB + OB) ? EFF_BITS - IB - OB : 1;
    localparam int EXT_W    = ADDR_W + IB + OB;
    localparam logic [ADDR_W-1:0] ADDR_MASK = (EFF_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
        ADDR_W'((64'd1 << EFF_BITS) - 64'd1);

    logic [EXT_W-1:0]  addr_ext;
    logic [IDX_W-1:0]  in_index;
    logic [SLOT_W-1:0] in_offset;
    logic [SLOT_W-1:0] in_slot;
    logic [TAG_W-1:0]  in_tag;

    logic [TAG_W:0]    tag_mem [LINES];
    logic [DATA_W-1:0] data_mem [DEPTH];
    logic [TAG_W:0]    tag_rd_reg;
    logic [DATA_W-1:0] data_rd_reg;

    dmc_state_t        state_reg, state_next;
    logic [SLOT_W-1:0] clr_slot_reg, clr_slot_next;
    logic [IDX_W-1:0]  clr_line_reg, clr_line_next;

    logic              req_valid_reg, req_valid_next;
    logic              req_mode_reg;
    logic [IDX_W-1:0]  req_index_reg;
    logic [SLOT_W-1:0] req_slot_reg;
    logic [TAG_W-1:0]  req_tag_reg;
    logic [DATA_W-1:0] req_wdata_reg;
    logic              fwd_tag_reg, fwd_tag_next;
    logic              fwd_data_reg, fwd_data_next;
    logic [TAG_W-1:0]  fwd_tag_val_reg;
    logic [DATA_W-1:0] fwd_word_reg;

    logic              m_valid_reg, m_valid_next;
    dmc_rsp_t          m_data_reg, m_data_next;

    logic              s_acc;
    logic              req_done;
    logic              req_write;
    logic [TAG_W:0]    req_line;
    logic [DATA_W-1:0] req_word;
    logic              req_hit;

    logic              tag_we;
    logic [IDX_W-1:0]  tag_waddr;
    logic [TAG_W:0]    tag_wdata;
    logic              data_we;
    logic [SLOT_W-1:0] data_waddr;
    logic [DATA_W-1:0] data_wdata;
    logic              run_ready;

    assign addr_ext = EXT_W'(s_data.address & ADDR_MASK);

    generate
        if (IB > 0) begin : g_index
            assign in_index = IDX_W'(addr_ext[OB +: IB]);
        end else begin : g_no_index
            assign in_index = '0;
        end
        if (OB > 0) begin : g_offset
            assign in_offset = SLOT_W'(addr_ext[0 +: OB]);
        end else begin : g_no_offset
            assign in_offset = '0;
        end
        if (EFF_BITS > IB + OB) begin : g_tag
            assign in_tag = addr_ext[IB + OB +: TAG_W];
        end else begin : g_no_tag
            assign in_tag = '0;
        end
    endgenerate

    assign in_slot = SLOT_W'(in_index) * SLOT_W'(WORDS_PER_LINE) + in_offset;

    // Request stage: resolve the lookup, with the previous write forwarded.
    assign req_write = req_valid_reg && (req_mode_reg == MODE_WRITE);
    assign req_done  = req_valid_reg && (!m_valid_reg || m_ready);
    assign req_line  = fwd_tag_reg ? {1'b1, fwd_tag_val_reg} : tag_rd_reg;
    assign req_word  = fwd_data_reg ? fwd_word_reg : data_rd_reg;
    assign req_hit   = req_line[TAG_W] && (req_line[TAG_W-1:0] == req_tag_reg);

    assign s_ready = run_ready && (!req_valid_reg || req_done);
    assign s_acc   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_slot_reg == SLOT_W'(DEPTH - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                state_next = ST_RUN;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        run_ready     = 1'b0;
        clr_slot_next = clr_slot_reg;
        clr_line_next = clr_line_reg;
        tag_we        = 1'b0;
        tag_waddr     = req_index_reg;
        tag_wdata     = {1'b1, req_tag_reg};
        data_we       = 1'b0;
        data_waddr    = req_slot_reg;
        data_wdata    = req_wdata_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                tag_we        = 1'b1;
                tag_waddr     = clr_line_reg;
                tag_wdata     = '0;
                data_we       = 1'b1;
                data_waddr    = clr_slot_reg;
                data_wdata    = '0;
                clr_slot_next = clr_slot_reg + SLOT_W'(1);
                if (clr_line_reg != IDX_W'(LINES - 1)) begin
                    clr_line_next = clr_line_reg + IDX_W'(1);
                end
            end
            ST_RUN: begin
                run_ready = 1'b1;
                tag_we    = req_done && req_write;
                data_we   = req_done && req_write;
            end
            default: begin
                run_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        fwd_tag_next  = req_done && req_write && (req_index_reg == in_index);
        fwd_data_next = req_done && req_write && (req_slot_reg == in_slot);

        req_valid_next = req_valid_reg;
        if (s_acc) begin
            req_valid_next = 1'b1;
        end else if (req_done) begin
            req_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (req_done) begin
            m_valid_next     = 1'b1;
            m_data_next.hit  = req_hit;
            if (req_mode_reg == MODE_WRITE) begin
                m_data_next.read_data = '0;
            end else if (req_hit) begin
                m_data_next.read_data = req_word;
            end else begin
                m_data_next.read_data = '1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (s_acc) begin
            tag_rd_reg <= tag_mem[in_index];
        end
    end

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[data_waddr] <= data_wdata;
        end
        if (s_acc) begin
            data_rd_reg <= data_mem[in_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            req_mode_reg    <= s_data.mode;
            req_index_reg   <= in_index;
            req_slot_reg    <= in_slot;
            req_tag_reg     <= in_tag;
            req_wdata_reg   <= s_data.write_data;
            fwd_tag_reg     <= fwd_tag_next;
            fwd_data_reg    <= fwd_data_next;
            fwd_tag_val_reg <= req_tag_reg;
            fwd_word_reg    <= req_wdata_reg;
        end
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_slot_reg  <= '0;
            clr_line_reg  <= '0;
            req_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_slot_reg  <= clr_slot_next;
            clr_line_reg  <= clr_line_next;
            req_valid_reg <= req_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/dmc_checker.sv =====
// Port-level checker for the direct-mapped cache, bound to its top level.
`include "direct_mapped_cache_defines.svh"

module dmc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input dmc_pkg::dmc_req_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input dmc_pkg::dmc_rsp_t  m_data
);
    import dmc_pkg::*;

    logic [1:0] pending_reg, pending_next;
    logic       s_xfer;
    logic       m_xfer;

    assign s_xfer = s_valid && s_ready;
    assign m_xfer = m_valid && m_ready;

    always_comb begin
        pending_next = pending_reg;
        if (s_xfer && !m_xfer) begin
            pending_next = pending_reg + 2'd1;
        end else if (m_xfer && !s_xfer) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // A stalled response transfer must hold its contents.
    `DMC_ASSERT_NEXT(a_rsp_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "response changed while stalled")

    // A response is only ever shown for a request that has been taken.
    `DMC_ASSERT_NOW(a_no_orphan_rsp, aclk, aresetn, m_valid,
        pending_reg != 2'd0, "response without an outstanding request")

    // A miss reports either all ones for a read or zero for a write.
    `DMC_ASSERT_NOW(a_miss_data, aclk, aresetn, m_valid && !m_data.hit,
        (m_data.read_data == '0) || (m_data.read_data == '1),
        "miss response carries a stored word")

    // The memories are swept after reset, so s_ready and m_valid must both be low just after reset is released.
    `DMC_ASSERT_NOW(a_reset_sweep, aclk, aresetn, !$past(aresetn),
        !s_ready && !m_valid, "request taken before the reset sweep")

endmodule

bind direct_mapped_cache dmc_checker u_dmc_checker (.*);

// ===== tb/sv/direct_mapped_cache_tb.sv =====
// Self-checking testbench for the direct-mapped write-allocate cache.
module direct_mapped_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmc_pkg::*;

    localparam int OFF_W        = $clog2(DMC_WORDS_PER_LINE);
    localparam int IDX_W        = $clog2(DMC_LINES);
    localparam int TAG_W        = DMC_ADDR_BITS - IDX_W - OFF_W;
    localparam int RANDOM_ITEMS = 1850;
    localparam int QUIET_ITEMS  = 200;
    localparam int PHASE_ITEMS  = 300;
    localparam int MAX_REPORTS  = 10;

    localparam int unsigned IDLE_STEPS [6] = '{10, 0, 35, 20, 0, 50};

    typedef struct {
        dmc_req_t req;
        bit       typed;
        dmc_rsp_t rsp;
    } access_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    dmc_req_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    dmc_rsp_t m_data;

    logic             line_valid [DMC_LINES];
    logic [TAG_W-1:0] line_tag   [DMC_LINES];
    logic [DATA_W-1:0] cache_words [DMC_LINES * DMC_WORDS_PER_LINE];

    dmc_rsp_t    pending_rsp [$];
    access_row_t directed_rows [$];
    int unsigned idle_pct = 0;
    int unsigned failures = 0;

    direct_mapped_cache dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic dmc_rsp_t cache_access(input dmc_req_t req);
        logic [OFF_W-1:0] word;
        logic [IDX_W-1:0] line;
        logic [TAG_W-1:0] tag;
        int unsigned      slot;
        dmc_rsp_t         rsp;
        word = req.address[OFF_W-1:0];
        line = req.address[OFF_W +: IDX_W];
        tag  = req.address[DMC_ADDR_BITS-1 -: TAG_W];
        slot = int'(line) * DMC_WORDS_PER_LINE + int'(word);
        rsp.hit = line_valid[line] && (line_tag[line] == tag);
        if (req.mode == MODE_WRITE) begin
            line_valid[line]  = 1'b1;
            line_tag[line]    = tag;
            cache_words[slot] = req.write_data;
            rsp.read_data     = '0;
        end else begin
            rsp.read_data = rsp.hit ? cache_words[slot] : '1;
        end
        return rsp;
    endfunction

    task automatic add_row(input logic mode, input logic [31:0] addr, input logic [31:0] wdata,
                           input bit typed, input logic hit, input logic [31:0] rdata);
        access_row_t row;
        row.req.mode       = mode;
        row.req.address    = addr;
        row.req.write_data = wdata;
        row.typed          = typed;
        row.rsp.hit        = hit;
        row.rsp.read_data  = rdata;
        directed_rows.push_back(row);
    endtask

    task automatic send_access(input dmc_req_t req, input bit typed, input dmc_rsp_t typed_rsp);
        dmc_rsp_t    predicted;
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = cache_access(req);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        dmc_req_t         req;
        logic [TAG_W-1:0] tag_pool [4];
        logic [IDX_W-1:0] line_sel;
        int unsigned      pick;
        foreach (line_valid[i]) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
        end
        foreach (cache_words[i]) cache_words[i] = '0;
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_W'($urandom());
        tag_pool[3] = TAG_W'($urandom());

        add_row(MODE_READ,  32'h0000_0000, 32'h0000_0000, 1, 1'b0, 32'hFFFF_FFFF);
        add_row(MODE_READ,  32'hFFFF_FFFF, 32'h1234_5678, 1, 1'b0, 32'hFFFF_FFFF);
        add_row(MODE_WRITE, 32'h0000_0000, 32'h7FFF_FFFF, 1, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'h0000_0000, 32'h0000_0000, 1, 1'b1, 32'h7FFF_FFFF);
        add_row(MODE_READ,  32'h0000_0001, 32'h0000_0000, 1, 1'b1, 32'h0000_0000);
        add_row(MODE_WRITE, 32'h0000_0001, 32'h8000_0000, 1, 1'b1, 32'h0000_0000);
        add_row(MODE_READ,  32'h0000_0001, 32'h0000_0000, 1, 1'b1, 32'h8000_0000);
        add_row(MODE_READ,  32'h0000_0100, 32'h0000_0000, 1, 1'b0, 32'hFFFF_FFFF);
        add_row(MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF);
        add_row(MODE_READ,  32'hFFFF_FFFC, 32'h0000_0000, 1, 1'b1, 32'h0000_0000);
        add_row(MODE_WRITE, 32'hFFFF_FF03, 32'h1234_5678, 1, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'h0000_0000, 32'h0000_0000, 1, 1'b0, 32'hFFFF_FFFF);
        add_row(MODE_READ,  32'hFFFF_FF00, 32'h0000_0000, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'hFFFF_FF01, 32'h0000_0000, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'hFFFF_FF03, 32'h0000_0000, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_WRITE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'hA5A5_A5A5, 32'hFFFF_FFFF, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_WRITE, 32'h0000_0404, 32'h0000_0001, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'h0000_0404, 32'hDEAD_BEEF, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_WRITE, 32'h0000_0405, 32'h0000_0002, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_WRITE, 32'h0000_0405, 32'h0000_0003, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'h0000_0405, 32'h0000_0000, 0, 1'b0, 32'h0000_0000);
        add_row(MODE_READ,  32'h0000_0406, 32'h0000_0000, 0, 1'b0, 32'h0000_0000);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        idle_pct = 20;
        foreach (directed_rows[r]) begin
            send_access(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].rsp);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct = (n >= RANDOM_ITEMS - QUIET_ITEMS) ? 0 : IDLE_STEPS[(n / PHASE_ITEMS) % 6];
            pick = $urandom_range(0, 99);
            req.mode = 1'($urandom_range(0, 1));
            if (pick < 5) begin
                req.write_data = 32'sh8000_0000;
            end else if (pick < 10) begin
                req.write_data = 32'sh7FFF_FFFF;
            end else begin
                req.write_data = $urandom();
            end
            if ($urandom_range(0, 4) == 0) begin
                req.address = $urandom();
            end else begin
                if ($urandom_range(0, 1) == 1) begin
                    line_sel = IDX_W'($urandom_range(0, 7));
                end else begin
                    line_sel = IDX_W'($urandom());
                end
                req.address = {tag_pool[$urandom_range(0, 3)], line_sel, OFF_W'($urandom())};
            end
            send_access(req, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        dmc_rsp_t    want;
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_rsp.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("unexpected transfer: hit=%0b read_data=%h",
                                 m_data.hit, m_data.read_data);
                    end
                end else begin
                    want = pending_rsp.pop_front();
                    if (m_data.hit !== want.hit || m_data.read_data !== want.read_data) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("mismatch: expected hit=%0b read_data=%h, %s%0b %s%h",
                                     want.hit, want.read_data, "got hit=", m_data.hit,
                                     "read_data=", m_data.read_data);
                        end
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(1, 11);
            end
            m_ready <= (stall_left == 0);
        end
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
